[rtl/abo_pkg.sv]
// Shared types, constants and the divider step function for the ARGB over blend.
package abo_pkg;

    localparam int unsigned LANES      = 3;
    localparam int unsigned DIV_STEPS  = 2;     // quotient bits resolved per divider stage
    localparam int unsigned DIV_STAGES = 8 / DIV_STEPS;   // stages for an 8-bit quotient

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [8:0] ALPHA_UNITY  = 9'd256;

    // One colour channel inside the divider: partial remainder, numerator
    // bits still to be shifted in, and the quotient built so far.
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] low;
        logic [7:0] quo;
    } t_div_lane;

    // Pixel word travelling down the divider stages.
    typedef struct packed {
        logic                   bypass;  // front alpha opaque or clear
        logic [31:0]            pix;     // pass-through pixel
        logic [7:0]             oa;      // output alpha, also the divisor
        t_div_lane [LANES-1:0]  lane;    // [2] red, [1] green, [0] blue
    } t_div_word;

    // One restoring division step: bring down the next numerator bit and
    // subtract the divisor if it fits.
    function automatic t_div_lane div_step(input t_div_lane l, input logic [7:0] d);
        logic [8:0] t;
        logic       fit;
        t_div_lane  n;
        t     = {l.rem, l.low[7]};
        fit   = (t >= {1'b0, d});
        n.rem = fit ? 8'(t - {1'b0, d}) : t[7:0];
        n.low = {l.low[6:0], 1'b0};
        n.quo = {l.quo[6:0], fit};
        return n;
    endfunction

endpackage

[rtl/argb_alpha_over_blend_top.sv]
// Top level of the Porter-Duff over blend of two 8-bit ARGB pixels.
//
// Usage:
//   Slave stream: one transfer carries a front and a back ARGB pixel.
//   Master stream: one transfer carries the blended ARGB pixel, in order.
//   Front alpha 255 passes the front pixel, front alpha 0 passes the back
//   pixel; otherwise alpha and colours follow the over rule with truncation.
// Pipeline: six register stages from the accepted input transfer to m_axis_tvalid.
// Throughput: one pixel per cycle while m_axis_tready is high; every stage
//   takes a new item in the same cycle its own item moves on (two front-end
//   stages for the alpha scaling and weighted sums, four divider stages
//   resolving two quotient bits each).
// Reset: synchronous, active low; clears every stage valid bit, so the
//   pipeline comes up empty and ready.
// Stall: when m_axis_tready is low the output holds; stages upstream keep
//   filling any empty slot, and s_axis_tready drops only once every stage
//   holds an item.
module argb_alpha_over_blend_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] front_argb, [63:32] back_argb
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] blended_argb
);

    logic               w_valid [abo_pkg::DIV_STAGES+1];
    logic               w_ready [abo_pkg::DIV_STAGES+1];
    abo_pkg::t_div_word w_word  [abo_pkg::DIV_STAGES+1];
    abo_pkg::t_div_word last;

    // Front end: scale alpha and form the weighted sums.
    abo_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_front (s_axis_tdata[31:0]),
        .i_back  (s_axis_tdata[63:32]),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_word  (w_word[0])
    );

    // Divider chain: each stage resolves two quotient bits per channel.
    for (genvar k = 0; k < abo_pkg::DIV_STAGES; k++) begin : g_div
        abo_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_word  (w_word[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_word  (w_word[k+1])
        );
    end

    assign w_ready[abo_pkg::DIV_STAGES] = m_axis_tready;
    assign last                         = w_word[abo_pkg::DIV_STAGES];

    // Select the pass-through pixel or the composed alpha and quotients.
    assign m_axis_tvalid = w_valid[abo_pkg::DIV_STAGES];
    assign m_axis_tdata  = last.bypass ? last.pix
                         : {last.oa, last.lane[2].quo, last.lane[1].quo, last.lane[0].quo};

    // A blended (not passed-through) result never has zero alpha.
    a_alpha_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !last.bypass) |-> (last.oa != 8'd0))
        else $error("blended result with zero alpha");

    // Input backpressure only when every divider stage is full and output stalls.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (w_valid[0] && w_valid[1] && w_valid[2] && w_valid[3]
                            && w_valid[4] && !m_axis_tready))
        else $error("input stalled while pipeline has a free slot");

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!m_axis_tvalid && !w_valid[0]))
        else $error("valid data after reset");

endmodule

[rtl/abo_front.sv]
// Front end: scaled back alpha, output alpha and per-channel weighted sums.
module abo_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [31:0]         i_front,
    input  logic [31:0]         i_back,
    output logic                o_valid,
    input  logic                i_ready,
    output abo_pkg::t_div_word  o_word
);

    typedef struct packed {
        logic                              bypass;
        logic [31:0]                       pix;
        logic [7:0]                        fa;
        logic [7:0]                        sb;
        logic [abo_pkg::LANES-1:0][7:0]    fc;
        logic [abo_pkg::LANES-1:0][7:0]    bc;
    } t_front_a;

    logic               r_a_valid;
    t_front_a           r_a;
    t_front_a           n_a;
    logic               r_b_valid;
    abo_pkg::t_div_word r_b;
    abo_pkg::t_div_word n_b;

    logic               a_ready;
    logic               b_ready;
    logic [7:0]         fa;
    logic [7:0]         ba;
    logic [16:0]        sb_prod;
    logic [8:0]         oa_sum;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // Stage A: classify and scale the back alpha.
    always_comb begin
        fa      = i_front[31:24];
        ba      = i_back[31:24];
        sb_prod = 17'({9'd0, ba} * {8'd0, abo_pkg::ALPHA_UNITY - {1'b0, fa}});
        n_a.fa  = fa;
        n_a.sb  = sb_prod[15:8];
        n_a.bypass = (fa == abo_pkg::ALPHA_OPAQUE) || (fa == abo_pkg::ALPHA_CLEAR);
        n_a.pix    = (fa == abo_pkg::ALPHA_OPAQUE) ? i_front : i_back;
        for (int i = 0; i < abo_pkg::LANES; i++) begin
            n_a.fc[i] = i_front[8*i +: 8];
            n_a.bc[i] = i_back[8*i +: 8];
        end
    end

    // Stage B: output alpha and weighted sums, loaded into the divider form.
    always_comb begin
        logic [16:0] num;
        oa_sum     = {1'b0, r_a.fa} + {1'b0, r_a.sb};
        n_b.bypass = r_a.bypass;
        n_b.pix    = r_a.pix;
        n_b.oa     = oa_sum[7:0];
        for (int i = 0; i < abo_pkg::LANES; i++) begin
            num = {1'b0, {8'd0, r_a.fc[i]} * {8'd0, r_a.fa}}
                + {1'b0, {8'd0, r_a.bc[i]} * {8'd0, r_a.sb}};
            n_b.lane[i].rem = num[15:8];
            n_b.lane[i].low = num[7:0];
            n_b.lane[i].quo = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) r_a_valid <= i_valid;
            if (b_ready) r_b_valid <= r_a_valid;
        end
        if (a_ready && i_valid)   r_a <= n_a;
        if (b_ready && r_a_valid) r_b <= n_b;
    end

    assign o_valid = r_b_valid;
    assign o_word  = r_b;

endmodule

[rtl/abo_div_stage.sv]
// One divider stage: two restoring quotient steps on all three channels.
module abo_div_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  abo_pkg::t_div_word  i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output abo_pkg::t_div_word  o_word
);

    logic               r_valid;
    abo_pkg::t_div_word r_word;
    abo_pkg::t_div_word n_word;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_word = i_word;
        for (int i = 0; i < abo_pkg::LANES; i++) begin
            for (int s = 0; s < abo_pkg::DIV_STEPS; s++) begin
                n_word.lane[i] = abo_pkg::div_step(n_word.lane[i], i_word.oa);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
